### hw/rtl/sdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants for the SD card SPI-mode responder.
// ----------------------------------------------------------------------------
package sdr_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int IDX_W        = $clog2(SECTOR_BYTES);
  localparam int PHASE_W      = 10;

  localparam logic [PHASE_W-1:0] READ_END   = PHASE_W'(SECTOR_BYTES + 2);
  localparam logic [PHASE_W-1:0] WRITE_RESP = PHASE_W'(SECTOR_BYTES + 4);
  localparam logic [PHASE_W-1:0] WRITE_END  = PHASE_W'(SECTOR_BYTES + 8);

  // reply and token bytes
  localparam logic [7:0] BYTE_IDLE     = 8'hFF;
  localparam logic [7:0] R1_IN_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY      = 8'h00;
  localparam logic [7:0] TOKEN_START   = 8'hFE;
  localparam logic [7:0] DATA_ACCEPTED = 8'h05;
  localparam logic [7:0] OCR_BYTE1     = 8'hC0;
  localparam logic [7:0] R7_ECHO       = 8'hAA;
  localparam logic [7:0] START_MASK    = 8'hC0;
  localparam logic [7:0] START_CODE    = 8'h40;
  localparam logic [7:0] CMD_MASK      = 8'h3F;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_SEND_IF    = 6'd8;
  localparam logic [5:0] CMD_STATUS     = 6'd13;
  localparam logic [5:0] CMD_READ_BLK   = 6'd17;
  localparam logic [5:0] CMD_WRITE_BLK  = 6'd24;
  localparam logic [5:0] CMD_APP_OP     = 6'd41;
  localparam logic [5:0] CMD_APP        = 6'd55;
  localparam logic [5:0] CMD_READ_OCR   = 6'd58;

  typedef enum logic [1:0] {
    KIND_SPI  = 2'd0,
    KIND_FILL = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_CMD    = 3'd1,
    MODE_R7     = 3'd2,
    MODE_OCR    = 3'd3,
    MODE_READ   = 3'd4,
    MODE_WRITE  = 3'd5,
    MODE_STATUS = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    SEL_KEEP  = 2'd0,
    SEL_CONST = 2'd1,
    SEL_MEM   = 2'd2
  } reply_sel_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       spi_byte;
    logic [IDX_W-1:0] buffer_index;
    logic [7:0]       buffer_byte;
  } item_t;

  typedef struct packed {
    reply_sel_t  sel;
    logic [7:0]  reply_const;
    logic        buf_rd;
    logic        load_request;
    logic        store_request;
    logic [31:0] sector_number;
    logic        protocol_error;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/sdr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_front
// Input side: decodes the item kind and holds items in a two-entry queue.
// ----------------------------------------------------------------------------
module sdr_front
  import sdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // spi_byte[7:0], buffer_index[16:8], buffer_byte[24:17]
  input  wire logic [1:0]  s_tuser,   // kind
  output logic             q_valid,
  input  wire logic        q_ready,
  output item_t            q_item
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      in_item;

  always_comb begin
    in_item.kind         = kind_t'(s_tuser);
    in_item.spi_byte     = s_tdata[7:0];
    in_item.buffer_index = s_tdata[16:8];
    in_item.buffer_byte  = s_tdata[24:17];
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sdr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_back
// Executes items: SPI command protocol, sector buffer and result register.
// ----------------------------------------------------------------------------
module sdr_back
  import sdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire item_t       q_item,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata
);

  logic [7:0] sector_store [SECTOR_BYTES];

  mode_t              mode, mode_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [5:0]         command_index, command_index_next;
  logic [31:0]        argument, argument_next;
  logic [31:0]        block_address, block_address_next;
  logic [7:0]         pending_response, pending_response_next;
  logic [7:0]         last_reply;

  logic               out_valid;
  result_t            out_res;
  result_t            res_next;
  logic [7:0]         rdata;

  logic               fire;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_addr;
  logic [7:0]         mem_wdata;
  logic [PHASE_W-1:0] phase_inc;
  logic [PHASE_W-1:0] phase_m2;
  logic [7:0]         reply_byte;
  logic [7:0]         b;

  assign q_ready   = !out_valid || m_tready;
  assign fire      = q_valid && q_ready;
  assign phase_inc = phase + PHASE_W'(1);
  assign phase_m2  = phase - PHASE_W'(2);
  assign b         = q_item.spi_byte;

  always_comb begin
    mode_next             = mode;
    phase_next            = phase;
    command_index_next    = command_index;
    argument_next         = argument;
    block_address_next    = block_address;
    pending_response_next = pending_response;
    mem_we                = 1'b0;
    mem_addr              = q_item.buffer_index;
    mem_wdata             = q_item.buffer_byte;
    res_next.sel            = SEL_KEEP;
    res_next.reply_const    = BYTE_IDLE;
    res_next.buf_rd         = 1'b0;
    res_next.load_request   = 1'b0;
    res_next.store_request  = 1'b0;
    res_next.protocol_error = 1'b0;

    unique case (q_item.kind)
      KIND_FILL: mem_we = 1'b1;
      KIND_READ: res_next.buf_rd = 1'b1;
      KIND_NONE: ;
      KIND_SPI: begin
        unique case (mode)
          MODE_CMD: begin
            if (phase < PHASE_W'(4)) begin
              argument_next = {argument[23:0], b};
              phase_next    = phase_inc;
            end else begin
              phase_next = '0;
              unique case (command_index) inside
                CMD_GO_IDLE, CMD_APP: begin
                  mode_next             = MODE_IDLE;
                  pending_response_next = R1_IN_IDLE;
                end
                CMD_SEND_IF: begin
                  mode_next             = MODE_R7;
                  pending_response_next = R1_READY;
                end
                CMD_STATUS: begin
                  mode_next             = MODE_STATUS;
                  pending_response_next = R1_READY;
                end
                CMD_READ_BLK: begin
                  mode_next          = MODE_READ;
                  block_address_next = argument;
                end
                CMD_WRITE_BLK: begin
                  mode_next          = MODE_WRITE;
                  block_address_next = argument;
                end
                CMD_APP_OP: begin
                  mode_next             = MODE_IDLE;
                  pending_response_next = R1_READY;
                end
                CMD_READ_OCR: begin
                  mode_next             = MODE_OCR;
                  pending_response_next = R1_READY;
                end
                default: begin
                  mode_next             = MODE_IDLE;
                  pending_response_next = BYTE_IDLE;
                end
              endcase
            end
          end
          MODE_R7: begin
            res_next.sel = SEL_CONST;
            if (b != BYTE_IDLE) begin
              res_next.sel            = SEL_KEEP;
              res_next.protocol_error = 1'b1;
              mode_next               = MODE_IDLE;
              phase_next              = '0;
            end else if (phase >= PHASE_W'(4)) begin
              res_next.reply_const = R7_ECHO;
              mode_next            = MODE_IDLE;
              phase_next           = '0;
            end else begin
              res_next.reply_const = R1_READY;
              phase_next           = phase_inc;
            end
          end
          MODE_OCR: begin
            if (b != BYTE_IDLE) begin
              res_next.protocol_error = 1'b1;
              mode_next               = MODE_IDLE;
              phase_next              = '0;
            end else begin
              res_next.sel = SEL_CONST;
              if (phase == PHASE_W'(0))      res_next.reply_const = R1_READY;
              else if (phase == PHASE_W'(1)) res_next.reply_const = OCR_BYTE1;
              else                           res_next.reply_const = BYTE_IDLE;
              if (phase >= PHASE_W'(4)) begin
                mode_next  = MODE_IDLE;
                phase_next = '0;
              end else begin
                phase_next = phase_inc;
              end
            end
          end
          MODE_STATUS: begin
            if (b != BYTE_IDLE) begin
              res_next.protocol_error = 1'b1;
              mode_next               = MODE_IDLE;
              phase_next              = '0;
            end else begin
              res_next.sel         = SEL_CONST;
              res_next.reply_const = R1_READY;
              if (phase >= PHASE_W'(1)) begin
                mode_next  = MODE_IDLE;
                phase_next = '0;
              end else begin
                phase_next = phase_inc;
              end
            end
          end
          MODE_READ: begin
            mem_addr = phase_m2[IDX_W-1:0];
            if (phase == PHASE_W'(0)) begin
              res_next.sel          = SEL_CONST;
              res_next.reply_const  = R1_READY;
              res_next.load_request = 1'b1;
            end else if (phase == PHASE_W'(1)) begin
              res_next.sel         = SEL_CONST;
              res_next.reply_const = TOKEN_START;
            end else if (phase < READ_END) begin
              res_next.sel = SEL_MEM;
            end
            phase_next = phase_inc;
            if (phase_inc >= READ_END) begin
              mode_next             = MODE_IDLE;
              phase_next            = '0;
              pending_response_next = BYTE_IDLE;
            end
          end
          MODE_WRITE: begin
            mem_addr   = phase_m2[IDX_W-1:0];
            mem_wdata  = b;
            phase_next = phase_inc;
            if (phase == PHASE_W'(0)) begin
              res_next.sel         = SEL_CONST;
              res_next.reply_const = R1_READY;
            end else if (phase == PHASE_W'(1)) begin
              if (b != TOKEN_START) begin
                res_next.protocol_error = 1'b1;
                mode_next               = MODE_IDLE;
                phase_next              = '0;
              end
            end else if (phase < READ_END) begin
              mem_we = 1'b1;
            end else if (phase == WRITE_RESP) begin
              res_next.sel         = SEL_CONST;
              res_next.reply_const = DATA_ACCEPTED;
            end else if (phase > WRITE_RESP) begin
              res_next.sel         = SEL_CONST;
              res_next.reply_const = BYTE_IDLE;
            end
            if (!res_next.protocol_error && phase_inc >= WRITE_END) begin
              mode_next              = MODE_IDLE;
              phase_next             = '0;
              pending_response_next  = R1_READY;
              res_next.store_request = 1'b1;
            end
          end
          default: begin
            // idle, and the unused mode code
            if (b == BYTE_IDLE) begin
              res_next.sel          = SEL_CONST;
              res_next.reply_const  = pending_response;
              pending_response_next = BYTE_IDLE;
            end else if ((b & START_MASK) == START_CODE) begin
              mode_next          = MODE_CMD;
              command_index_next = 6'(b & CMD_MASK);
              argument_next      = '0;
              phase_next         = '0;
            end
          end
        endcase
      end
      default: ;
    endcase

    res_next.sector_number = block_address_next;
  end

  // sector buffer, one port, registered read
  always_ff @(posedge clk) begin
    if (fire) begin
      if (mem_we) begin
        sector_store[mem_addr] <= mem_wdata;
      end
      rdata <= sector_store[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      phase            <= '0;
      command_index    <= '0;
      argument         <= '0;
      block_address    <= '0;
      pending_response <= BYTE_IDLE;
      last_reply       <= BYTE_IDLE;
      out_valid        <= 1'b0;
    end else begin
      if (fire) begin
        mode             <= mode_next;
        phase            <= phase_next;
        command_index    <= command_index_next;
        argument         <= argument_next;
        block_address    <= block_address_next;
        pending_response <= pending_response_next;
      end
      if (out_valid && m_tready) begin
        last_reply <= reply_byte;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    unique case (out_res.sel)
      SEL_CONST: reply_byte = out_res.reply_const;
      SEL_MEM:   reply_byte = rdata;
      default:   reply_byte = last_reply;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0,
                     out_res.protocol_error,
                     out_res.sector_number,
                     out_res.store_request,
                     out_res.load_request,
                     (out_res.buf_rd ? rdata : 8'd0),
                     reply_byte};

`ifndef ASSERT_OFF
  a_rdata_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> $stable(rdata))
    else $error("buffer read data changed under a stalled result");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDLE) |-> (phase == '0))
    else $error("idle with nonzero phase");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase < WRITE_END)
    else $error("phase ran past the end of a block transfer");

  a_req_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.load_request && out_res.store_request))
    else $error("load and store requested together");

  a_err_keeps_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.protocol_error) |-> (out_res.sel == SEL_KEEP))
    else $error("protocol error changed the reply");
`endif

endmodule
`default_nettype wire

### hw/rtl/sd_card_spi_responder.sv
`default_nettype none
// A result is offered once its item has passed the queue register, then the
// protocol stage with its registered sector buffer read. Throughput: one item
// per cycle while the output is not stalled; the two-entry input queue and the
// result register let input and output stall independently.
// Reset: synchronous, active high; protocol state returns to idle, replies to
// 0xFF. Sector buffer contents are undefined until written.
// ----------------------------------------------------------------------------
// sd_card_spi_responder
// SD card target in SPI mode, one exchanged byte or buffer access per item.
// ----------------------------------------------------------------------------
module sd_card_spi_responder
  import sdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // spi_byte[7:0], buffer_index[16:8], buffer_byte[24:17]
  input  wire logic [1:0]  s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // reply_byte[7:0], buffer_out[15:8], load_request[16],
                                      // store_request[17], sector_number[49:18],
                                      // protocol_error[50]
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  sdr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  sdr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire
